// ===== hdl/hsp_pkg.sv =====
// Shared types and constants for the heading and speed P controller.
// Used by the steering and drive calculation modules and by the top level.
// No dependencies.
package hsp_pkg;

    // Steering constants, signed to match the error arithmetic.
    localparam logic signed [12:0] HALF_TURN    = 13'sd1800;
    localparam logic signed [12:0] FULL_TURN    = 13'sd3600;
    localparam logic signed [17:0] CENTER_PULSE = 18'sd2769;
    localparam logic signed [17:0] RIGHT_PULSE  = 18'sd3329;
    localparam logic signed [17:0] LEFT_PULSE   = 18'sd1909;

    // Drive constants.
    localparam logic [15:0] NEUTRAL_PULSE = 16'd2769;
    localparam logic [15:0] REVERSE_PULSE = 16'd2030;

    // Reset values of the tunable registers.
    localparam logic [3:0] HEADING_GAIN_RESET    = 4'd1;
    localparam logic [5:0] SPEED_GAIN_RESET      = 6'd1;
    localparam logic [7:0] LIGHT_THRESHOLD_RESET = 8'd200;

    // Input item kinds.
    localparam logic OP_COMPASS = 1'b0;
    localparam logic OP_RANGER  = 1'b1;

    // Register indexes on the configuration channel.
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 12;
    localparam logic [CFG_INDEX_W-1:0] REG_TARGET_HEADING     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_HEADING_GAIN       = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_OBSTACLE_THRESHOLD = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SPEED_GAIN         = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_SPEED_OFFSET       = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_LIGHT_THRESHOLD    = 3'd5;

    // Tunable registers as seen by the calculation modules.
    typedef struct packed {
        logic [11:0] target_heading;
        logic [3:0]  heading_gain;
        logic [9:0]  obstacle_threshold;
        logic [5:0]  speed_gain;
        logic [9:0]  speed_offset;
        logic [7:0]  light_threshold;
    } t_cfg;

    // New drive state produced by a ranger sample.
    typedef struct packed {
        logic [15:0] drive_value;
        logic        reverse_flag;
    } t_drive_state;

endpackage

// ===== hdl/hsp_steer_calc.sv =====
// Steering pulse calculation for one compass sample.
// Depends on hsp_pkg for the pulse limits and turn constants.
module hsp_steer_calc (
    input  logic [11:0] i_target_heading,
    input  logic [3:0]  i_heading_gain,
    input  logic [11:0] i_heading_sample,
    input  logic        i_reverse_flag,
    output logic [11:0] o_steer_value
);

    logic signed [12:0] w_err_raw;
    logic signed [12:0] w_err_wrap;
    logic signed [12:0] w_err_dir;
    logic signed [17:0] w_prod;
    logic signed [17:0] w_pulse;

    // Heading error, wrapped once into the half-turn window.
    assign w_err_raw = $signed({1'b0, i_target_heading}) - $signed({1'b0, i_heading_sample});

    always_comb begin
        if (w_err_raw > hsp_pkg::HALF_TURN) begin
            w_err_wrap = w_err_raw - hsp_pkg::FULL_TURN;
        end else if (w_err_raw < -hsp_pkg::HALF_TURN) begin
            w_err_wrap = w_err_raw + hsp_pkg::FULL_TURN;
        end else begin
            w_err_wrap = w_err_raw;
        end
    end

    // Steering sense flips while the car backs up.
    assign w_err_dir = i_reverse_flag ? -w_err_wrap : w_err_wrap;

    // Gain, centre offset and clamp to the servo range.
    assign w_prod  = $signed({1'b0, i_heading_gain}) * w_err_dir;
    assign w_pulse = w_prod + hsp_pkg::CENTER_PULSE;

    always_comb begin
        if (w_pulse > hsp_pkg::RIGHT_PULSE) begin
            o_steer_value = hsp_pkg::RIGHT_PULSE[11:0];
        end else if (w_pulse < hsp_pkg::LEFT_PULSE) begin
            o_steer_value = hsp_pkg::LEFT_PULSE[11:0];
        end else begin
            o_steer_value = w_pulse[11:0];
        end
    end

endmodule

// ===== hdl/hsp_drive_calc.sv =====
// Drive pulse and reverse decision for one ranger sample.
// Depends on hsp_pkg for the register struct, drive constants and result struct.
module hsp_drive_calc (
    input  hsp_pkg::t_cfg         i_cfg,
    input  logic [15:0]           i_range_sample,
    input  logic [7:0]            i_light_sample,
    output hsp_pkg::t_drive_state o_drive
);

    logic [15:0]        w_base;
    logic [9:0]         w_half;
    logic [9:0]         w_diff;
    logic [15:0]        w_slow;
    logic signed [17:0] w_reduced;
    logic               w_near;
    logic               w_far_half;

    // Forward drive before any obstacle slowdown.
    assign w_base = hsp_pkg::NEUTRAL_PULSE + {6'b0, i_cfg.speed_offset};

    // Obstacle window: below the threshold and above half of it.
    assign w_half     = i_cfg.obstacle_threshold >> 1;
    assign w_near     = i_range_sample < {6'b0, i_cfg.obstacle_threshold};
    assign w_far_half = i_range_sample > {6'b0, w_half};

    // Linear slowdown; the range is below the threshold whenever this is used.
    assign w_diff    = i_cfg.obstacle_threshold - i_range_sample[9:0];
    assign w_slow    = {10'b0, i_cfg.speed_gain} * {6'b0, w_diff};
    assign w_reduced = $signed({2'b0, w_base}) - $signed({2'b0, w_slow});

    always_comb begin
        if (i_light_sample > i_cfg.light_threshold) begin
            o_drive.reverse_flag = 1'b1;
            o_drive.drive_value  = hsp_pkg::REVERSE_PULSE;
        end else begin
            o_drive.reverse_flag = 1'b0;
            if (!w_near) begin
                o_drive.drive_value = w_base;
            end else if (!w_far_half) begin
                o_drive.drive_value = hsp_pkg::NEUTRAL_PULSE;
            end else if (w_reduced < 18'sd0) begin
                // Slowdown larger than the base pulse saturates at zero.
                o_drive.drive_value = 16'd0;
            end else begin
                o_drive.drive_value = w_reduced[15:0];
            end
        end
    end

endmodule

// ===== hdl/heading_and_speed_p_controller_core.sv =====
// Top level of the heading and speed P controller: registers, state and handshakes.
// Depends on hsp_pkg, hsp_steer_calc and hsp_drive_calc.
//
// Usage:
//   Input stream (s_axis): tuser selects the sample kind (0 compass, 1 ranger),
//   tdata carries heading, range and light. Each transaction yields exactly one
//   result transaction on the output stream (m_axis) with the current steering
//   pulse, drive pulse and reverse flag.
//   Configuration channel: index and data, always ready, one register per write;
//   the user makes writes only while no sample is in flight; the block does not enforce it.
//   Result path: the accepting edge loads the input register; the result register
//   is loaded from it after one pass through the steering or drive logic, once the
//   result register is free or being emptied.
//   Throughput: one sample per cycle unless the receiver stalls; the state used by a
//   sample is the one the previous sample left, updated in the same pass as the result.
//   Reset: steering pulse 0, drive pulse 2769 (neutral), forward, registers at
//   their reset values, both stages empty.
//   Receiver stall: the result register holds; the input register holds behind
//   it and s_axis tready falls until the result transaction completes.
module heading_and_speed_p_controller_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Input stream.
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // tdata: [11:0] heading_sample, [27:12] range_sample, [35:28] light_sample,
    // [39:36] zero
    input  logic [39:0]                     i_s_axis_tdata,
    // tuser: [0] opcode
    input  logic                            i_s_axis_tuser,
    // Result stream.
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // tdata: [11:0] steer_pulse, [27:12] drive_pulse, [28] reversing, [31:29] zero
    output logic [31:0]                     o_m_axis_tdata,
    // Configuration write channel.
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [hsp_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [hsp_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    hsp_pkg::t_cfg         r_cfg;
    hsp_pkg::t_drive_state w_drive;

    logic        r_in_valid;
    logic        r_in_opcode;
    logic [11:0] r_in_heading;
    logic [15:0] r_in_range;
    logic [7:0]  r_in_light;

    logic [11:0] r_steer_value;
    logic [15:0] r_drive_value;
    logic        r_reverse_flag;
    logic [11:0] n_steer_value;
    logic [15:0] n_drive_value;
    logic        n_reverse_flag;

    logic        r_out_valid;
    logic [31:0] r_out_data;

    logic [11:0] w_steer;
    logic        w_advance;
    logic        w_in_accept;

    // Configuration registers; unknown indexes are dropped.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.target_heading     <= '0;
            r_cfg.heading_gain       <= hsp_pkg::HEADING_GAIN_RESET;
            r_cfg.obstacle_threshold <= '0;
            r_cfg.speed_gain         <= hsp_pkg::SPEED_GAIN_RESET;
            r_cfg.speed_offset       <= '0;
            r_cfg.light_threshold    <= hsp_pkg::LIGHT_THRESHOLD_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                hsp_pkg::REG_TARGET_HEADING:     r_cfg.target_heading     <= i_cfg_data[11:0];
                hsp_pkg::REG_HEADING_GAIN:       r_cfg.heading_gain       <= i_cfg_data[3:0];
                hsp_pkg::REG_OBSTACLE_THRESHOLD: r_cfg.obstacle_threshold <= i_cfg_data[9:0];
                hsp_pkg::REG_SPEED_GAIN:         r_cfg.speed_gain         <= i_cfg_data[5:0];
                hsp_pkg::REG_SPEED_OFFSET:       r_cfg.speed_offset       <= i_cfg_data[9:0];
                hsp_pkg::REG_LIGHT_THRESHOLD:    r_cfg.light_threshold    <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    // The input stage moves on when the result register is free or being emptied.
    assign w_advance       = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || w_advance;
    assign w_in_accept     = i_s_axis_tvalid && o_s_axis_tready;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_in_opcode  <= i_s_axis_tuser;
            r_in_heading <= i_s_axis_tdata[11:0];
            r_in_range   <= i_s_axis_tdata[27:12];
            r_in_light   <= i_s_axis_tdata[35:28];
        end
    end

    // Calculation units.
    hsp_steer_calc u_steer (
        .i_target_heading (r_cfg.target_heading),
        .i_heading_gain   (r_cfg.heading_gain),
        .i_heading_sample (r_in_heading),
        .i_reverse_flag   (r_reverse_flag),
        .o_steer_value    (w_steer)
    );

    hsp_drive_calc u_drive (
        .i_cfg          (r_cfg),
        .i_range_sample (r_in_range),
        .i_light_sample (r_in_light),
        .o_drive        (w_drive)
    );

    // Each sample kind updates only its own part of the state.
    always_comb begin
        n_steer_value  = r_steer_value;
        n_drive_value  = r_drive_value;
        n_reverse_flag = r_reverse_flag;
        if (r_in_opcode == hsp_pkg::OP_COMPASS) begin
            n_steer_value = w_steer;
        end else begin
            n_drive_value  = w_drive.drive_value;
            n_reverse_flag = w_drive.reverse_flag;
        end
    end

    // Controller state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_steer_value  <= '0;
            r_drive_value  <= hsp_pkg::NEUTRAL_PULSE;
            r_reverse_flag <= 1'b0;
        end else if (w_advance) begin
            r_steer_value  <= n_steer_value;
            r_drive_value  <= n_drive_value;
            r_reverse_flag <= n_reverse_flag;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_data <= {3'b0, n_reverse_flag, n_drive_value, n_steer_value};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    // Reverse mode always drives the reverse pulse.
    a_reverse_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_reverse_flag |-> (r_drive_value == hsp_pkg::REVERSE_PULSE))
        else $error("reverse flag set without reverse drive pulse");

    // Steering pulse is zero before the first heading, otherwise inside the servo range.
    a_steer_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_steer_value == 12'd0) ||
        ((r_steer_value >= hsp_pkg::LEFT_PULSE[11:0]) &&
         (r_steer_value <= hsp_pkg::RIGHT_PULSE[11:0])))
        else $error("steering pulse outside servo range");

    // A compass sample leaves the drive state alone.
    a_compass_keeps_drive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && (r_in_opcode == hsp_pkg::OP_COMPASS)) |=>
        ($stable(r_drive_value) && $stable(r_reverse_flag)))
        else $error("compass sample changed drive state");

    // A ranger sample leaves the steering state alone.
    a_ranger_keeps_steer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && (r_in_opcode == hsp_pkg::OP_RANGER)) |=> $stable(r_steer_value))
        else $error("ranger sample changed steering state");

    // A processed sample always lands in the result register.
    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance |=> r_out_valid)
        else $error("processed sample produced no result");

endmodule

// ===== bench/tb.sv =====
// Self-checking bench for heading_and_speed_p_controller_core: directed and random
// samples on the input stream, each result compared against a steering/drive predictor.
// Depends on hsp_pkg and the controller RTL.
`timescale 1ns / 100ps

module tb;
    import hsp_pkg::*;

    // Register indexes with no register behind them; writes to them must be dropped.
    localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED_LO = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED_HI = 3'd7;

    // One expected result transaction.
    typedef struct packed {
        logic [11:0] steer_pulse;
        logic [15:0] drive_pulse;
        logic        reversing;
    } t_pulse_set;

    // Predicts the controller state per accepted sample and checks each result.
    class pulse_scoreboard;
        logic [11:0] target_heading;
        logic [3:0]  heading_gain;
        logic [9:0]  obstacle_threshold;
        logic [5:0]  speed_gain;
        logic [9:0]  speed_offset;
        logic [7:0]  light_threshold;
        logic [11:0] steer_value;
        logic [15:0] drive_value;
        logic        reverse_flag;
        t_pulse_set  pulse_q[$];
        int          mismatches;
        int          results_seen;

        function new();
            target_heading     = '0;
            heading_gain       = HEADING_GAIN_RESET;
            obstacle_threshold = '0;
            speed_gain         = SPEED_GAIN_RESET;
            speed_offset       = '0;
            light_threshold    = LIGHT_THRESHOLD_RESET;
            steer_value        = '0;
            drive_value        = NEUTRAL_PULSE;
            reverse_flag       = 1'b0;
            mismatches         = 0;
            results_seen       = 0;
        endfunction

        function void report_mismatch(string what);
            $display("[%0t] MISMATCH result %0d: %s", $realtime, results_seen, what);
            mismatches++;
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
            case (index)
                REG_TARGET_HEADING:     target_heading     = data[11:0];
                REG_HEADING_GAIN:       heading_gain       = data[3:0];
                REG_OBSTACLE_THRESHOLD: obstacle_threshold = data[9:0];
                REG_SPEED_GAIN:         speed_gain         = data[5:0];
                REG_SPEED_OFFSET:       speed_offset       = data[9:0];
                REG_LIGHT_THRESHOLD:    light_threshold    = data[7:0];
                default: ;
            endcase
        endfunction

        // Update the state for one accepted sample and queue the resulting pulses.
        function void note_sample(logic op, logic [39:0] data);
            logic [11:0] heading;
            logic [15:0] range_val;
            logic [7:0]  light;
            int          err;
            int          pw;
            int          drive;
            t_pulse_set  res;
            heading   = data[11:0];
            range_val = data[27:12];
            light     = data[35:28];
            if (op == OP_COMPASS) begin
                // Heading error wrapped once into a half turn either way.
                err = int'(target_heading) - int'(heading);
                if (err > int'(HALF_TURN)) begin
                    err -= int'(FULL_TURN);
                end else if (err < -int'(HALF_TURN)) begin
                    err += int'(FULL_TURN);
                end
                if (reverse_flag) begin
                    err = -err;
                end
                pw = int'(heading_gain) * err + int'(CENTER_PULSE);
                if (pw > int'(RIGHT_PULSE)) begin
                    pw = int'(RIGHT_PULSE);
                end
                if (pw < int'(LEFT_PULSE)) begin
                    pw = int'(LEFT_PULSE);
                end
                steer_value = 12'(pw);
            end else if (light > light_threshold) begin
                reverse_flag = 1'b1;
                drive_value  = REVERSE_PULSE;
            end else begin
                // Forward drive, slowed linearly near an obstacle.
                reverse_flag = 1'b0;
                drive_value  = 16'(int'(NEUTRAL_PULSE) + int'(speed_offset));
                if (range_val < obstacle_threshold) begin
                    if (range_val > obstacle_threshold / 2) begin
                        drive = int'(NEUTRAL_PULSE) + int'(speed_offset)
                              - int'(speed_gain) * (int'(obstacle_threshold) - int'(range_val));
                        if (drive < 0) begin
                            drive = 0;
                        end
                        drive_value = 16'(drive);
                    end else begin
                        drive_value = NEUTRAL_PULSE;
                    end
                end
            end
            res.steer_pulse = steer_value;
            res.drive_pulse = drive_value;
            res.reversing   = reverse_flag;
            pulse_q.push_back(res);
        endfunction

        // Compare one result transaction with the oldest expectation.
        function void check_result(logic [31:0] data);
            t_pulse_set exp_res;
            if (pulse_q.size() == 0) begin
                report_mismatch($sformatf("unexpected result 0x%08h", data));
            end else begin
                exp_res = pulse_q.pop_front();
                if (data[11:0] !== exp_res.steer_pulse) begin
                    report_mismatch($sformatf("steer_pulse %0d, want %0d",
                                              data[11:0], exp_res.steer_pulse));
                end
                if (data[27:12] !== exp_res.drive_pulse) begin
                    report_mismatch($sformatf("drive_pulse %0d, want %0d",
                                              data[27:12], exp_res.drive_pulse));
                end
                if (data[28] !== exp_res.reversing) begin
                    report_mismatch($sformatf("reversing %0b, want %0b",
                                              data[28], exp_res.reversing));
                end
                if (data[31:29] !== 3'b000) begin
                    report_mismatch($sformatf("padding bits %03b", data[31:29]));
                end
            end
            results_seen++;
        endfunction

        function int pending();
            return pulse_q.size();
        endfunction
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [39:0]            s_tdata = '0;
    logic                   s_tuser = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [31:0]            m_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    // Idle controls shared between the stimulus and the receiver.
    bit tx_idle_on = 1'b1;
    bit rx_idle_on = 1'b1;
    bit hold_req   = 1'b0;

    pulse_scoreboard sb = new();

    heading_and_speed_p_controller_core uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    // Clock generation.
    initial begin
        forever begin
            #5 i_clk = ~i_clk;
        end
    end

    // Safety net against a hung handshake.
    initial begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

    // Receiver: checks result transactions and stalls in random bursts.
    initial begin
        int stall_left;
        stall_left = 0;
        @(posedge i_clk);
        while (!i_rst_n) begin
            @(posedge i_clk);
        end
        forever begin
            @(posedge i_clk);
            if (m_tvalid && m_tready) begin
                sb.check_result(m_tdata);
            end
            if (hold_req) begin
                // Long hold-off so that the pipeline fills and the input stalls.
                hold_req   = 1'b0;
                stall_left = 60;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (rx_idle_on && $urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(0, 12);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Offer one sample and wait for its transaction, with an optional idle burst first.
    task automatic send_sample(input logic op, input logic [39:0] data);
        if (tx_idle_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= data;
        @(posedge i_clk);
        while (!s_tready) begin
            @(posedge i_clk);
        end
        sb.note_sample(op, data);
    endtask

    // Compass sample; the ranger fields carry random content that must be ignored.
    task automatic send_compass(input logic [11:0] heading);
        send_sample(OP_COMPASS, {4'd0, 8'($urandom), 16'($urandom), heading});
    endtask

    // Ranger sample; the heading field carries random content that must be ignored.
    task automatic send_ranger(input logic [15:0] range_val, input logic [7:0] light);
        send_sample(OP_RANGER, {4'd0, light, range_val, 12'($urandom)});
    endtask

    // Random sample with ranges and light levels clustered around the thresholds.
    task automatic send_random();
        logic        op;
        logic [11:0] heading;
        logic [15:0] range_val;
        logic [7:0]  light;
        int          lo;
        int          hi;
        op = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 4) == 0) begin
            heading = 12'($urandom_range(0, 4095));
        end else begin
            heading = 12'($urandom_range(0, 3599));
        end
        if ($urandom_range(0, 3) == 0) begin
            range_val = 16'($urandom);
        end else begin
            range_val = 16'($urandom_range(0, int'(sb.obstacle_threshold) + 2));
        end
        if ($urandom_range(0, 1) == 0) begin
            light = 8'($urandom);
        end else begin
            lo    = (sb.light_threshold > 3) ? int'(sb.light_threshold) - 3 : 0;
            hi    = (sb.light_threshold < 252) ? int'(sb.light_threshold) + 3 : 255;
            light = 8'($urandom_range(lo, hi));
        end
        send_sample(op, {4'd0, light, range_val, heading});
    endtask

    // One register write transaction; the caller lowers valid after the last one.
    task automatic cfg_write(input logic [CFG_INDEX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge i_clk);
        while (!cfg_ready) begin
            @(posedge i_clk);
        end
        sb.write_reg(index, data);
    endtask

    // Stop offering samples and wait until every result has come back or the limit runs out.
    task automatic drain(input int limit);
        int waited;
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        for (waited = 0; waited < limit && sb.pending() != 0; waited++) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    // Mostly in-range value with occasional extremes and over-wide raw data.
    function automatic logic [CFG_DATA_W-1:0] pick_setting(int hi);
        int r;
        r = $urandom_range(0, 7);
        if (r == 0) begin
            return '0;
        end else if (r == 1) begin
            return CFG_DATA_W'(hi);
        end else if (r == 2) begin
            return CFG_DATA_W'($urandom_range(0, 4095));
        end
        return CFG_DATA_W'($urandom_range(0, hi));
    endfunction

    task automatic random_settings();
        cfg_write(REG_TARGET_HEADING, pick_setting(3599));
        cfg_write(REG_HEADING_GAIN, pick_setting(15));
        cfg_write(REG_OBSTACLE_THRESHOLD, pick_setting(1023));
        cfg_write(REG_SPEED_GAIN, pick_setting(63));
        cfg_write(REG_SPEED_OFFSET, pick_setting(736));
        cfg_write(REG_LIGHT_THRESHOLD, pick_setting(255));
        if ($urandom_range(0, 2) == 0) begin
            cfg_write($urandom_range(0, 1) ? REG_UNMAPPED_HI : REG_UNMAPPED_LO,
                      CFG_DATA_W'($urandom));
        end
        cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Main sequence.
    initial begin
        int phase;
        int n;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: wrap limits, steering clamps, light threshold and reversing.
        send_compass(12'd0);
        send_compass(12'd1800);
        send_compass(12'd1801);
        send_compass(12'd3599);
        send_compass(12'hFFF);
        send_ranger(16'd0, 8'd200);
        send_ranger(16'd0, 8'd201);
        send_compass(12'd100);
        send_ranger(16'd0, 8'd255);
        send_ranger(16'hFFFF, 8'd0);
        drain(2000);

        // Upper extremes: maximum gains and threshold, offset 736, light threshold zero.
        cfg_write(REG_TARGET_HEADING, 12'd3599);
        cfg_write(REG_HEADING_GAIN, 12'd15);
        cfg_write(REG_OBSTACLE_THRESHOLD, 12'd1023);
        cfg_write(REG_SPEED_GAIN, 12'd63);
        cfg_write(REG_SPEED_OFFSET, 12'd736);
        cfg_write(REG_LIGHT_THRESHOLD, 12'd0);
        cfg_valid <= 1'b0;
        @(posedge i_clk);
        send_compass(12'd0);
        send_compass(12'd3599);
        send_compass(12'd2000);
        send_ranger(16'd0, 8'd0);
        send_ranger(16'd511, 8'd0);
        send_ranger(16'd512, 8'd0);
        send_ranger(16'd1022, 8'd0);
        send_ranger(16'd1023, 8'd0);
        send_ranger(16'hFFFF, 8'd0);
        send_ranger(16'd0, 8'd1);
        drain(2000);

        // Lower extremes, over-wide data and writes to unmapped indexes.
        cfg_write(REG_TARGET_HEADING, 12'hFFF);
        cfg_write(REG_HEADING_GAIN, 12'd0);
        cfg_write(REG_OBSTACLE_THRESHOLD, 12'd0);
        cfg_write(REG_SPEED_GAIN, 12'd0);
        cfg_write(REG_SPEED_OFFSET, 12'hFFF);
        cfg_write(REG_LIGHT_THRESHOLD, 12'hFFF);
        cfg_write(REG_UNMAPPED_LO, 12'hABC);
        cfg_write(REG_UNMAPPED_HI, 12'h000);
        cfg_valid <= 1'b0;
        @(posedge i_clk);
        send_compass(12'd1234);
        send_ranger(16'd0, 8'd255);
        drain(2000);

        // Random phases, each under fresh settings.
        for (phase = 0; phase < 10; phase++) begin
            random_settings();
            tx_idle_on = (phase != 9) && (phase != 2);
            rx_idle_on = (phase != 9);
            if (phase == 2) begin
                hold_req = 1'b1;
            end
            for (n = 0; n < 55; n++) begin
                send_random();
            end
            drain(4000);
        end

        repeat (10) @(posedge i_clk);
        if (sb.pending() != 0) begin
            sb.report_mismatch($sformatf("%0d results never arrived", sb.pending()));
        end
        if (sb.mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
